### rtl/core/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared widths, constants, item types and the CORDIC arctangent table for
// the polar vector adder/subtracter.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int ITER_DEFAULT = 24;
    localparam int ANGLE_ENTRIES = 32;
    localparam int GUARD_BITS = 8;
    localparam int COMP_W = 45;
    localparam int ZANG_W = 34;
    localparam int MAG_IN_W = 32;
    localparam int DIR_W = 16;
    localparam int MAG_OUT_W = 33;

    localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;
    localparam logic [DIR_W-1:0] DIR_FULL = 16'd46080;
    localparam logic [DIR_W-1:0] DIR_90 = 16'd11520;
    localparam logic [DIR_W-1:0] DIR_270 = 16'd34560;
    localparam logic [MAG_OUT_W-1:0] MAG_MAX = '1;
    // ceil(2^22 / 45): reciprocal for the quotient of a direction by 45
    localparam logic [16:0] RECIP_45 = 17'd93207;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [ZANG_W-1:0] zang_t;

    typedef enum logic [1:0] {
        QUAD_1 = 2'd0,
        QUAD_2 = 2'd1,
        QUAD_3 = 2'd2,
        QUAD_4 = 2'd3
    } quad_t;

    typedef enum logic {
        REQ_ADD = 1'b0,
        REQ_SUB = 1'b1
    } req_t;

    typedef struct packed {
        logic                 req_type;
        logic [MAG_IN_W-1:0]  first_magnitude;
        logic [DIR_W-1:0]     first_direction;
        logic [MAG_IN_W-1:0]  second_magnitude;
        logic [DIR_W-1:0]     second_direction;
    } in_item_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        zang_t z;
        quad_t quad;
    } rot_lane_t;

    typedef struct packed {
        req_t      req;
        rot_lane_t a;
        rot_lane_t b;
    } rot_item_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        zang_t z;
        logic  x_zero;
        logic  y_neg;
    } vec_item_t;

    typedef struct packed {
        logic [MAG_OUT_W-1:0] sum_magnitude;
        logic [DIR_W-1:0]     sum_direction;
    } out_item_t;

    // arctan(2^-i) in binary-angle units (2^32 = one turn)
    function automatic logic [31:0] angle_step(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            5'd24:   r = 32'h00000029;
            5'd25:   r = 32'h00000014;
            5'd26:   r = 32'h0000000A;
            5'd27:   r = 32'h00000005;
            5'd28:   r = 32'h00000003;
            5'd29:   r = 32'h00000001;
            5'd30:   r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/pva_ifs.sv
// ----------------------------------------------------------------------------
// pva channel interfaces
// Valid/ready channels for operand pairs and for polar results.
// ----------------------------------------------------------------------------
interface pva_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] first_magnitude;
    logic [15:0] first_direction;
    logic [31:0] second_magnitude;
    logic [15:0] second_direction;

    modport source (
        output valid, req_type, first_magnitude, first_direction,
               second_magnitude, second_direction,
        input  ready
    );
    modport sink (
        input  valid, req_type, first_magnitude, first_direction,
               second_magnitude, second_direction,
        output ready
    );
endinterface

interface pva_out_if;
    logic        valid;
    logic        ready;
    logic [32:0] sum_magnitude;
    logic [15:0] sum_direction;

    modport source (
        output valid, sum_magnitude, sum_direction,
        input  ready
    );
    modport sink (
        input  valid, sum_magnitude, sum_direction,
        output ready
    );
endinterface

### rtl/core/pva_front.sv
// ----------------------------------------------------------------------------
// pva_front
// Two stages: reduce directions to binary angles and prescale magnitudes
// into CORDIC start vectors.
// ----------------------------------------------------------------------------
module pva_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  pva_pkg::in_item_t    in_item,
    output logic                 in_ready,
    output logic                 out_valid,
    output pva_pkg::rot_item_t   out_item,
    input  logic                 out_ready
);

    typedef struct packed {
        logic [15:0] dmod;
        logic [32:0] qprod;
        logic [63:0] prod;
    } pre_lane_t;

    typedef struct packed {
        logic      req_type;
        pre_lane_t a;
        pre_lane_t b;
    } pre_item_t;

    logic              v1_reg;
    logic              v2_reg;
    pre_item_t         s1_reg;
    pre_item_t         s1_next;
    pva_pkg::rot_item_t s2_reg;
    pva_pkg::rot_item_t s2_next;
    logic              en1;
    logic              en2;
    logic [21:0]       frac_tbl [64];

    // floor((b * 2^22 + 22) / 45) for each remainder b
    for (genvar g = 0; g < 64; g++) begin : g_frac
        assign frac_tbl[g] = (g < 45) ? 22'((((64'(g)) << 22) + 64'd22) / 45) : 22'd0;
    end

    function automatic pre_lane_t prep(input logic [31:0] mag, input logic [15:0] dir);
        pre_lane_t r;
        r.dmod  = (dir >= pva_pkg::DIR_FULL) ? dir - pva_pkg::DIR_FULL : dir;
        r.qprod = 33'(r.dmod) * 33'(pva_pkg::RECIP_45);
        r.prod  = 64'(mag) * 64'(pva_pkg::INV_GAIN_Q32);
        return r;
    endfunction

    function automatic pva_pkg::rot_lane_t start(input pre_lane_t p, input logic [21:0] frac);
        pva_pkg::rot_lane_t r;
        logic [9:0]  quo;
        logic [31:0] phase;
        logic [63:0] rnd;
        quo   = p.qprod[31:22];
        phase = {quo, 22'd0} + {10'd0, frac};
        rnd   = p.prod + (64'd1 << 23);
        r.x    = pva_pkg::comp_t'({5'd0, rnd[63:24]});
        r.y    = '0;
        r.z    = pva_pkg::zang_t'({4'd0, phase[29:0]});
        r.quad = pva_pkg::quad_t'(phase[31:30]);
        return r;
    endfunction

    logic [15:0] rem_a;
    logic [15:0] rem_b;

    always_comb
    begin
        s1_next.req_type = in_item.req_type;
        s1_next.a = prep(in_item.first_magnitude, in_item.first_direction);
        s1_next.b = prep(in_item.second_magnitude, in_item.second_direction);
        rem_a = s1_reg.a.dmod - 16'(s1_reg.a.qprod[31:22]) * 16'd45;
        rem_b = s1_reg.b.dmod - 16'(s1_reg.b.qprod[31:22]) * 16'd45;
        s2_next.req = pva_pkg::req_t'(s1_reg.req_type);
        s2_next.a = start(s1_reg.a, frac_tbl[rem_a[5:0]]);
        s2_next.b = start(s1_reg.b, frac_tbl[rem_b[5:0]]);
    end

    assign en2 = ~v2_reg | out_ready;
    assign en1 = ~v1_reg | en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
    end

    assign in_ready  = en1;
    assign out_valid = v2_reg;
    assign out_item  = s2_reg;

endmodule

### rtl/core/pva_rotate.sv
// ----------------------------------------------------------------------------
// pva_rotate
// Rotation-mode CORDIC, one register stage per iteration, two lanes side by
// side (first and second vector).
// ----------------------------------------------------------------------------
module pva_rotate #(
    parameter int ITER = pva_pkg::ITER_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  pva_pkg::rot_item_t in_item,
    output logic               in_ready,
    output logic               out_valid,
    output pva_pkg::rot_item_t out_item,
    input  logic               out_ready
);

    logic [ITER-1:0]    v_reg;
    pva_pkg::rot_item_t d_reg [ITER];
    logic [ITER:0]      en;

    assign en[ITER] = out_ready;

    for (genvar g = 0; g < ITER; g++) begin : g_stage
        localparam logic [31:0] STEP = pva_pkg::angle_step(5'(g));
        pva_pkg::rot_item_t cur;
        pva_pkg::rot_item_t d_next;
        logic               v_in;

        if (g == 0) begin : g_head
            assign cur  = in_item;
            assign v_in = in_valid;
        end else begin : g_body
            assign cur  = d_reg[g-1];
            assign v_in = v_reg[g-1];
        end

        assign en[g] = ~v_reg[g] | en[g+1];

        always_comb
        begin
            d_next = cur;
            // advance z toward zero
            if (!cur.a.z[pva_pkg::ZANG_W-1])
            begin
                d_next.a.x = cur.a.x - (cur.a.y >>> g);
                d_next.a.y = cur.a.y + (cur.a.x >>> g);
                d_next.a.z = cur.a.z - pva_pkg::zang_t'(STEP);
            end
            else
            begin
                d_next.a.x = cur.a.x + (cur.a.y >>> g);
                d_next.a.y = cur.a.y - (cur.a.x >>> g);
                d_next.a.z = cur.a.z + pva_pkg::zang_t'(STEP);
            end
            if (!cur.b.z[pva_pkg::ZANG_W-1])
            begin
                d_next.b.x = cur.b.x - (cur.b.y >>> g);
                d_next.b.y = cur.b.y + (cur.b.x >>> g);
                d_next.b.z = cur.b.z - pva_pkg::zang_t'(STEP);
            end
            else
            begin
                d_next.b.x = cur.b.x + (cur.b.y >>> g);
                d_next.b.y = cur.b.y - (cur.b.x >>> g);
                d_next.b.z = cur.b.z + pva_pkg::zang_t'(STEP);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en[g])
            begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                d_reg[g] <= d_next;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[ITER-1];
    assign out_item  = d_reg[ITER-1];

endmodule

### rtl/core/pva_vector.sv
// ----------------------------------------------------------------------------
// pva_vector
// Quadrant restore, add/subtract, half-plane fold, then vectoring-mode
// CORDIC with one register stage per iteration.
// ----------------------------------------------------------------------------
module pva_vector #(
    parameter int ITER = pva_pkg::ITER_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  pva_pkg::rot_item_t in_item,
    output logic               in_ready,
    output logic               out_valid,
    output pva_pkg::vec_item_t out_item,
    input  logic               out_ready
);

    typedef struct packed {
        pva_pkg::comp_t x;
        pva_pkg::comp_t y;
    } xy_t;

    function automatic xy_t unfold(input pva_pkg::rot_lane_t l);
        xy_t r;
        case (l.quad)
            pva_pkg::QUAD_1: begin r.x = l.x;  r.y = l.y;  end
            pva_pkg::QUAD_2: begin r.x = -l.y; r.y = l.x;  end
            pva_pkg::QUAD_3: begin r.x = -l.x; r.y = -l.y; end
            pva_pkg::QUAD_4: begin r.x = l.y;  r.y = -l.x; end
            default:         begin r.x = l.x;  r.y = l.y;  end
        endcase
        return r;
    endfunction

    logic               c1_v_reg;
    logic               c2_v_reg;
    xy_t                c1_reg;
    xy_t                c1_next;
    pva_pkg::vec_item_t c2_reg;
    pva_pkg::vec_item_t c2_next;
    logic               en_c1;
    logic               en_c2;
    xy_t                ua;
    xy_t                ub;

    logic [ITER-1:0]    v_reg;
    pva_pkg::vec_item_t d_reg [ITER];
    logic [ITER:0]      en;

    always_comb
    begin
        ua = unfold(in_item.a);
        ub = unfold(in_item.b);
        if (in_item.req == pva_pkg::REQ_SUB)
        begin
            c1_next.x = ua.x - ub.x;
            c1_next.y = ua.y - ub.y;
        end
        else
        begin
            c1_next.x = ua.x + ub.x;
            c1_next.y = ua.y + ub.y;
        end

        c2_next.x_zero = (c1_reg.x == '0);
        c2_next.y_neg  = c1_reg.y[pva_pkg::COMP_W-1];
        // fold the left half-plane over by a half turn
        if (c1_reg.x[pva_pkg::COMP_W-1])
        begin
            c2_next.x = -c1_reg.x;
            c2_next.y = -c1_reg.y;
            c2_next.z = pva_pkg::zang_t'(34'sd1 <<< 31);
        end
        else
        begin
            c2_next.x = c1_reg.x;
            c2_next.y = c1_reg.y;
            c2_next.z = '0;
        end
    end

    assign en[ITER] = out_ready;
    assign en_c2 = ~c2_v_reg | en[0];
    assign en_c1 = ~c1_v_reg | en_c2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_v_reg <= 1'b0;
            c2_v_reg <= 1'b0;
        end
        else
        begin
            if (en_c1)
            begin
                c1_v_reg <= in_valid;
            end
            if (en_c2)
            begin
                c2_v_reg <= c1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c1)
        begin
            c1_reg <= c1_next;
        end
        if (en_c2)
        begin
            c2_reg <= c2_next;
        end
    end

    for (genvar g = 0; g < ITER; g++) begin : g_stage
        localparam logic [31:0] STEP = pva_pkg::angle_step(5'(g));
        pva_pkg::vec_item_t cur;
        pva_pkg::vec_item_t d_next;
        logic               v_in;

        if (g == 0) begin : g_head
            assign cur  = c2_reg;
            assign v_in = c2_v_reg;
        end else begin : g_body
            assign cur  = d_reg[g-1];
            assign v_in = v_reg[g-1];
        end

        assign en[g] = ~v_reg[g] | en[g+1];

        always_comb
        begin
            d_next = cur;
            // drive y toward zero, accumulate the angle in z
            if (cur.y[pva_pkg::COMP_W-1])
            begin
                d_next.x = cur.x - (cur.y >>> g);
                d_next.y = cur.y + (cur.x >>> g);
                d_next.z = cur.z - pva_pkg::zang_t'(STEP);
            end
            else
            begin
                d_next.x = cur.x + (cur.y >>> g);
                d_next.y = cur.y - (cur.x >>> g);
                d_next.z = cur.z + pva_pkg::zang_t'(STEP);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en[g])
            begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                d_reg[g] <= d_next;
            end
        end
    end

    assign in_ready  = en_c1;
    assign out_valid = v_reg[ITER-1];
    assign out_item  = d_reg[ITER-1];

endmodule

### rtl/core/pva_back.sv
// ----------------------------------------------------------------------------
// pva_back
// Two stages: gain correction of the magnitude (split multiply) and angle
// conversion to 1/128 degree, with wrap and the x-zero override.
// ----------------------------------------------------------------------------
module pva_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  pva_pkg::vec_item_t in_item,
    output logic               in_ready,
    output logic               out_valid,
    output pva_pkg::out_item_t out_item,
    input  logic               out_ready
);

    typedef struct packed {
        logic [44:0] ph;
        logic [63:0] pl;
        logic [47:0] dprod;
        logic        x_zero;
        logic        y_neg;
    } prod_t;

    logic               v1_reg;
    logic               v2_reg;
    prod_t              p_reg;
    prod_t              p_next;
    pva_pkg::out_item_t o_reg;
    pva_pkg::out_item_t o_next;
    logic               en1;
    logic               en2;
    logic [76:0]        total;
    logic [36:0]        mag_full;
    logic [48:0]        dsum;
    logic [16:0]        dval;

    always_comb
    begin
        p_next.ph     = 45'(in_item.x[44:32]) * 45'(pva_pkg::INV_GAIN_Q32);
        p_next.pl     = 64'(in_item.x[31:0]) * 64'(pva_pkg::INV_GAIN_Q32);
        p_next.dprod  = 48'(in_item.z[31:0]) * 48'(pva_pkg::DIR_FULL);
        p_next.x_zero = in_item.x_zero;
        p_next.y_neg  = in_item.y_neg;

        total    = {p_reg.ph, 32'd0} + 77'(p_reg.pl)
                   + (77'd1 << (31 + pva_pkg::GUARD_BITS));
        mag_full = total[76:40];
        o_next.sum_magnitude = (mag_full > 37'(pva_pkg::MAG_MAX)) ?
                               pva_pkg::MAG_MAX : mag_full[32:0];

        dsum = 49'(p_reg.dprod) + (49'd1 << 31);
        dval = dsum[48:32];
        if (p_reg.x_zero)
        begin
            o_next.sum_direction = p_reg.y_neg ? pva_pkg::DIR_270 : pva_pkg::DIR_90;
        end
        else if (dval >= 17'(pva_pkg::DIR_FULL))
        begin
            o_next.sum_direction = '0;
        end
        else
        begin
            o_next.sum_direction = dval[15:0];
        end
    end

    assign en2 = ~v2_reg | out_ready;
    assign en1 = ~v1_reg | en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            p_reg <= p_next;
        end
        if (en2)
        begin
            o_reg <= o_next;
        end
    end

    assign in_ready  = en1;
    assign out_valid = v2_reg;
    assign out_item  = o_reg;

endmodule

### rtl/core/polar_vector_add_sub.sv
// Path: an operand transfer passes the front stages, the rotation CORDIC chain,
// the vector stages and the back stages, each stage registered, to the result.
// Throughput: one operand pair per cycle while results are taken; every stage
// holds its own valid bit and takes an item when empty or its successor moves.
// Reset: rst_n clears all valid bits asynchronously; data registers are
// not reset. No other state exists.
// ----------------------------------------------------------------------------
// polar_vector_add_sub
// Adds or subtracts two polar vectors: rotation CORDIC to x/y, add/sub,
// vectoring CORDIC back to magnitude and direction.
// ----------------------------------------------------------------------------
module polar_vector_add_sub #(
    parameter int CORDIC_ITERATIONS = pva_pkg::ITER_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    pva_in_if.sink    operands,
    pva_out_if.source result
);

    pva_pkg::in_item_t  in_item;
    pva_pkg::rot_item_t front_item;
    pva_pkg::rot_item_t rot_item;
    pva_pkg::vec_item_t vec_item;
    pva_pkg::out_item_t res_item;

    logic front_valid;
    logic front_ready;
    logic rot_valid;
    logic rot_ready;
    logic vec_valid;
    logic vec_ready;

    // gather the operand transfer into one payload word
    assign in_item.req_type         = operands.req_type;
    assign in_item.first_magnitude  = operands.first_magnitude;
    assign in_item.first_direction  = operands.first_direction;
    assign in_item.second_magnitude = operands.second_magnitude;
    assign in_item.second_direction = operands.second_direction;

    // direction reduction and magnitude prescale
    pva_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operands.valid),
        .in_item   (in_item),
        .in_ready  (operands.ready),
        .out_valid (front_valid),
        .out_item  (front_item),
        .out_ready (front_ready)
    );

    // both vectors to x/y in parallel lanes
    pva_rotate #(
        .ITER (CORDIC_ITERATIONS)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .in_ready  (front_ready),
        .out_valid (rot_valid),
        .out_item  (rot_item),
        .out_ready (rot_ready)
    );

    // combine and measure the sum vector
    pva_vector #(
        .ITER (CORDIC_ITERATIONS)
    ) u_vector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_item   (rot_item),
        .in_ready  (rot_ready),
        .out_valid (vec_valid),
        .out_item  (vec_item),
        .out_ready (vec_ready)
    );

    // gain correction and direction scaling; its last register is the
    // output register, so a stalled result holds while upstream keeps filling
    pva_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec_valid),
        .in_item   (vec_item),
        .in_ready  (vec_ready),
        .out_valid (result.valid),
        .out_item  (res_item),
        .out_ready (result.ready)
    );

    assign result.sum_magnitude = res_item.sum_magnitude;
    assign result.sum_direction = res_item.sum_direction;

endmodule

### rtl/core/pva_checker.sv
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks on the polar vector adder/subtracter.
// ----------------------------------------------------------------------------
module pva_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [32:0] sum_magnitude,
    input logic [15:0] sum_direction
);

    // a waiting result holds until its transfer
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sum_magnitude)
                                    && $stable(sum_direction))
        else $error("result changed while stalled");

    // direction always lands below a full turn
    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sum_direction < pva_pkg::DIR_FULL)
        else $error("direction out of range");

    // an empty output stage or a taken result frees the whole pipeline
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("operands blocked with output free");

    // reset empties the pipeline
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind polar_vector_add_sub pva_checker u_pva_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (operands.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .sum_magnitude (result.sum_magnitude),
    .sum_direction (result.sum_direction)
);
